@@ design/akvm_pkg.sv @@
// Package for the array key/value map.
// Sizes, widths and operation codes; no dependencies.
package akvm_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FETCH  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_STORE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

endpackage

@@ design/array_key_value_map.sv @@
// Array key/value map, top level. Uses akvm_pkg (scoped names).
// One word in flight: input ready returns in the same cycle as the result word turns valid,
// once the output register is free; one entry is read per cycle in scan and shift.
// Reset: control, fill count and output valid clear; memory contents stay undefined.
module array_key_value_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [akvm_pkg::FUNC_W-1:0] func,
    input  logic [akvm_pkg::KEY_W-1:0]  key,
    input  logic [akvm_pkg::VAL_W-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [akvm_pkg::VAL_W-1:0]  read_value,
    output logic [akvm_pkg::CNT_W-1:0]  entry_count,
    output logic                        full_error
);

    // Entry memories: one write port, one registered read port each.
    logic [akvm_pkg::KEY_W-1:0] key_mem [akvm_pkg::CAPACITY];
    logic [akvm_pkg::VAL_W-1:0] val_mem [akvm_pkg::CAPACITY];

    akvm_pkg::state_t state_reg, state_next;

    logic [akvm_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [akvm_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [akvm_pkg::VAL_W-1:0]  value_reg, value_next;
    logic [akvm_pkg::CNT_W-1:0]  count_reg, count_next;

    // Scan/shift read pointer; one wider than an index so it can reach count.
    logic [akvm_pkg::CNT_W-1:0]  addr_reg, addr_next;
    // Scan compare stage: read issued last cycle for this index.
    logic                        pend_vld_reg, pend_vld_next;
    logic [akvm_pkg::IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    // Shift stage: entry read last cycle moves down to this index.
    logic                        wr_vld_reg, wr_vld_next;
    logic [akvm_pkg::IDX_W-1:0]  wr_idx_reg, wr_idx_next;

    // Result held until the output register is free.
    logic                        res_found_reg, res_found_next;
    logic [akvm_pkg::VAL_W-1:0]  res_value_reg, res_value_next;
    logic                        res_ferr_reg, res_ferr_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic [akvm_pkg::VAL_W-1:0]  read_value_reg, read_value_next;
    logic [akvm_pkg::CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic                        full_error_reg, full_error_next;

    // Memory ports.
    logic [akvm_pkg::KEY_W-1:0]  key_rd_reg;
    logic [akvm_pkg::VAL_W-1:0]  val_rd_reg;
    logic [akvm_pkg::IDX_W-1:0]  mem_raddr;
    logic [akvm_pkg::IDX_W-1:0]  mem_waddr;
    logic                        key_we;
    logic                        val_we;
    logic [akvm_pkg::KEY_W-1:0]  key_wdata;
    logic [akvm_pkg::VAL_W-1:0]  val_wdata;

    logic                        hit;
    logic                        is_insert;

    assign in_ready    = (state_reg == akvm_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign full_error  = full_error_reg;

    // Key in the compare stage matches the request.
    assign hit       = pend_vld_reg && (key_rd_reg == key_reg);
    assign is_insert = (func_reg == akvm_pkg::FN_FETCH) || (func_reg == akvm_pkg::FN_STORE);

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[mem_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[mem_waddr] <= val_wdata;
        end
        val_rd_reg <= val_mem[mem_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        pend_vld_next    = 1'b0;
        pend_idx_next    = pend_idx_reg;
        wr_vld_next      = 1'b0;
        wr_idx_next      = wr_idx_reg;
        res_found_next   = res_found_reg;
        res_value_next   = res_value_reg;
        res_ferr_next    = res_ferr_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        read_value_next  = read_value_reg;
        entry_count_next = entry_count_reg;
        full_error_next  = full_error_reg;

        mem_raddr = addr_reg[akvm_pkg::IDX_W-1:0];
        mem_waddr = wr_idx_reg;
        key_we    = 1'b0;
        val_we    = 1'b0;
        key_wdata = key_rd_reg;
        val_wdata = val_rd_reg;

        unique case (state_reg)
            akvm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = func;
                    key_next       = key;
                    value_next     = value;
                    addr_next      = '0;
                    res_found_next = 1'b0;
                    res_value_next = '0;
                    res_ferr_next  = 1'b0;
                    if (func == akvm_pkg::FN_CLEAR)
                    begin
                        count_next = '0;
                        state_next = akvm_pkg::S_DONE;
                    end
                    else if (func > akvm_pkg::FN_CLEAR)
                    begin
                        // unused code: table untouched
                        state_next = akvm_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = akvm_pkg::S_SCAN;
                    end
                end
            end

            akvm_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    state_next     = akvm_pkg::S_DONE;
                    if (func_reg == akvm_pkg::FN_STORE)
                    begin
                        mem_waddr      = pend_idx_reg;
                        val_we         = 1'b1;
                        val_wdata      = value_reg;
                        res_value_next = value_reg;
                    end
                    else if (func_reg == akvm_pkg::FN_ERASE)
                    begin
                        res_value_next = '0;
                        addr_next      = akvm_pkg::CNT_W'(pend_idx_reg) + 1'b1;
                        state_next     = akvm_pkg::S_SHIFT;
                    end
                    else
                    begin
                        res_value_next = val_rd_reg;
                    end
                end
                else if (addr_reg >= count_reg)
                begin
                    // key absent
                    state_next = akvm_pkg::S_DONE;
                    if (is_insert)
                    begin
                        if (count_reg < akvm_pkg::CNT_W'(akvm_pkg::CAPACITY))
                        begin
                            mem_waddr  = count_reg[akvm_pkg::IDX_W-1:0];
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            key_wdata  = key_reg;
                            val_wdata  = (func_reg == akvm_pkg::FN_STORE) ? value_reg : '0;
                            res_value_next = val_wdata;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_ferr_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    addr_next     = addr_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = addr_reg[akvm_pkg::IDX_W-1:0];
                end
            end

            akvm_pkg::S_SHIFT:
            begin
                // read entry j+1 while entry read last cycle lands one place down
                if (wr_vld_reg)
                begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                end
                if (addr_reg < count_reg)
                begin
                    addr_next   = addr_reg + 1'b1;
                    wr_vld_next = 1'b1;
                    wr_idx_next = addr_reg[akvm_pkg::IDX_W-1:0] - 1'b1;
                end
                else if (!wr_vld_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = akvm_pkg::S_DONE;
                end
            end

            akvm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = res_found_reg;
                    read_value_next  = res_value_reg;
                    entry_count_next = count_reg;
                    full_error_next  = res_ferr_reg;
                    state_next       = akvm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = akvm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= akvm_pkg::S_IDLE;
            count_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            wr_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_vld_reg  <= pend_vld_next;
            wr_vld_reg    <= wr_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        addr_reg        <= addr_next;
        pend_idx_reg    <= pend_idx_next;
        wr_idx_reg      <= wr_idx_next;
        res_found_reg   <= res_found_next;
        res_value_reg   <= res_value_next;
        res_ferr_reg    <= res_ferr_next;
        found_reg       <= found_next;
        read_value_reg  <= read_value_next;
        entry_count_reg <= entry_count_next;
        full_error_reg  <= full_error_next;
    end

endmodule

@@ test/tb_array_key_value_map.sv @@
// Testbench for array_key_value_map: directed table, then random request words.
// Each result word is checked against a local model of the key/value table, or against the row's own expected result.
// Depends on akvm_pkg and array_key_value_map.
module tb_array_key_value_map;

    // Codes with no operation behind them; the block must leave the table alone.
    localparam logic [akvm_pkg::FUNC_W-1:0] FN_RSVD_A = 3'd5;
    localparam logic [akvm_pkg::FUNC_W-1:0] FN_RSVD_B = 3'd6;
    localparam logic [akvm_pkg::FUNC_W-1:0] FN_RSVD_C = 3'd7;

    localparam int RANDOM_WORDS  = 1500;
    localparam int IDLE_LIMIT    = 3000;  // cycles with no handshake on either side
    localparam int HOLD_AT       = 200;   // result word before which the receiver backs off
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 10;

    localparam logic [akvm_pkg::KEY_W-1:0] KEY_ALL1 = '1;
    localparam logic [akvm_pkg::VAL_W-1:0] VAL_ALL1 = '1;

    typedef struct packed {
        logic [akvm_pkg::FUNC_W-1:0] func;
        logic [akvm_pkg::KEY_W-1:0]  key;
        logic [akvm_pkg::VAL_W-1:0]  value;
    } map_request_t;

    typedef struct packed {
        logic                       found;
        logic [akvm_pkg::VAL_W-1:0] read_value;
        logic [akvm_pkg::CNT_W-1:0] entry_count;
        logic                       full_error;
    } map_result_t;

    typedef struct packed {
        map_request_t req;
        logic         typed;   // expected result given in the row itself
        map_result_t  res;
    } directed_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [akvm_pkg::FUNC_W-1:0] func;
    logic [akvm_pkg::KEY_W-1:0]  key;
    logic [akvm_pkg::VAL_W-1:0]  value;
    logic                        out_valid;
    logic                        out_ready;
    logic                        found;
    logic [akvm_pkg::VAL_W-1:0]  read_value;
    logic [akvm_pkg::CNT_W-1:0]  entry_count;
    logic                        full_error;

    // Local copy of the table: entries below table_fill are live, in insertion order.
    logic [akvm_pkg::KEY_W-1:0] table_keys [akvm_pkg::CAPACITY];
    logic [akvm_pkg::VAL_W-1:0] table_vals [akvm_pkg::CAPACITY];
    int                         table_fill = 0;

    map_result_t   pending_results [$];
    directed_row_t directed_rows [$];
    int            errors        = 0;
    int            results_taken = 0;
    int            idle_cycles   = 0;
    bit            send_burst    = 1'b0;
    bit            take_burst    = 1'b0;

    array_key_value_map i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count),
        .full_error  (full_error)
    );

    always #10 clk = ~clk;

    // Apply one request to the local table and return the result word it should give.
    function automatic map_result_t map_apply(map_request_t req);
        map_result_t r;
        int          slot;
        bit          hit;
        r    = '0;
        slot = table_fill;
        // keys are unique, so scanning from the top finds the same slot
        for (int i = table_fill - 1; i >= 0; i--)
            if (table_keys[i] == req.key)
                slot = i;
        hit = slot < table_fill;
        case (req.func)
            akvm_pkg::FN_LOOKUP:
                if (hit)
                begin
                    r.found      = 1'b1;
                    r.read_value = table_vals[slot];
                end
            akvm_pkg::FN_FETCH, akvm_pkg::FN_STORE:
                if (hit)
                begin
                    r.found = 1'b1;
                    if (req.func == akvm_pkg::FN_STORE)
                        table_vals[slot] = req.value;
                    r.read_value = table_vals[slot];
                end
                else if (table_fill < akvm_pkg::CAPACITY)
                begin
                    table_keys[table_fill] = req.key;
                    table_vals[table_fill] = (req.func == akvm_pkg::FN_STORE) ? req.value : '0;
                    r.read_value           = table_vals[table_fill];
                    table_fill++;
                end
                else
                    r.full_error = 1'b1;  // table full, insert refused
            akvm_pkg::FN_ERASE:
                if (hit)
                begin
                    r.found = 1'b1;
                    // close the gap: later entries move down one place
                    for (int j = slot; j < table_fill - 1; j++)
                    begin
                        table_keys[j] = table_keys[j + 1];
                        table_vals[j] = table_vals[j + 1];
                    end
                    table_fill--;
                end
            akvm_pkg::FN_CLEAR:
                table_fill = 0;
            default:
                ;
        endcase
        r.entry_count = akvm_pkg::CNT_W'(table_fill);
        return r;
    endfunction

    // Mostly keys already in the table, so hits, updates and erases are common.
    function automatic logic [akvm_pkg::KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (table_fill > 0 && sel < 6)
            return table_keys[$urandom_range(0, table_fill - 1)];
        if (sel == 9)
            return $urandom_range(0, 1) ? KEY_ALL1 : '0;
        return $urandom;
    endfunction

    function automatic logic [akvm_pkg::FUNC_W-1:0] pick_func();
        int w;
        w = $urandom_range(0, 99);
        if (w < 25)
            return akvm_pkg::FN_LOOKUP;
        if (w < 45)
            return akvm_pkg::FN_FETCH;
        if (w < 72)
            return akvm_pkg::FN_STORE;
        if (w < 95)
            return akvm_pkg::FN_ERASE;
        if (w < 97)
            return akvm_pkg::FN_CLEAR;
        // one of the unused codes
        return akvm_pkg::FUNC_W'($urandom_range(FN_RSVD_A, FN_RSVD_C));
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic add_row(logic [akvm_pkg::FUNC_W-1:0] f, logic [akvm_pkg::KEY_W-1:0] k,
                           logic [akvm_pkg::VAL_W-1:0] v, logic typed, logic fnd,
                           logic [akvm_pkg::VAL_W-1:0] rv, int cnt, logic ferr);
        directed_row_t row;
        row.req   = '{func: f, key: k, value: v};
        row.typed = typed;
        row.res   = '{found: fnd, read_value: rv, entry_count: akvm_pkg::CNT_W'(cnt),
                      full_error: ferr};
        directed_rows.push_back(row);
    endtask

    // Offer one request word after a random gap; on acceptance log what it must return.
    // valid is only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_word(map_request_t req, logic typed, map_result_t typed_res);
        int          gap;
        map_result_t predicted;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= req.func;
        key      <= req.key;
        value    <= req.value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = map_apply(req);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random(logic [akvm_pkg::FUNC_W-1:0] f, logic [akvm_pkg::KEY_W-1:0] k);
        map_request_t req;
        req = '{func: f, key: k, value: $urandom};
        // extremes of the value field now and then
        if ($urandom_range(0, 15) == 0)
            req.value = $urandom_range(0, 1) ? VAL_ALL1 : '0;
        send_word(req, 1'b0, '0);
    endtask

    // Stimulus: reset, directed table, then random blocks.
    initial
    begin
        int sent;
        int n;
        int kind;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = akvm_pkg::FN_LOOKUP;
        key      = '0;
        value    = '0;

        // Directed rows, starting from an empty table.
        add_row(akvm_pkg::FN_LOOKUP, '0,           '0,           1, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_ERASE,  '0,           '0,           1, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_STORE,  '0,           VAL_ALL1,     1, 0, VAL_ALL1,     1, 0);
        add_row(akvm_pkg::FN_STORE,  KEY_ALL1,     '0,           1, 0, '0,           2, 0);
        add_row(akvm_pkg::FN_FETCH,  32'h12345678, VAL_ALL1,     1, 0, '0,           3, 0);
        add_row(akvm_pkg::FN_LOOKUP, '0,           '0,           1, 1, VAL_ALL1,     3, 0);
        add_row(akvm_pkg::FN_STORE,  KEY_ALL1,     32'hA5A5A5A5, 1, 1, 32'hA5A5A5A5, 3, 0);
        add_row(akvm_pkg::FN_FETCH,  KEY_ALL1,     '0,           1, 1, 32'hA5A5A5A5, 3, 0);
        add_row(akvm_pkg::FN_STORE,  32'h12345678, 32'h5A5A5A5A, 1, 1, 32'h5A5A5A5A, 3, 0);
        add_row(FN_RSVD_A,           '0,           '0,           1, 0, '0,           3, 0);
        add_row(FN_RSVD_B,           32'h12345678, VAL_ALL1,     1, 0, '0,           3, 0);
        add_row(FN_RSVD_C,           KEY_ALL1,     VAL_ALL1,     1, 0, '0,           3, 0);
        add_row(akvm_pkg::FN_ERASE,  '0,           '0,           1, 1, '0,           2, 0);
        add_row(akvm_pkg::FN_LOOKUP, 32'h12345678, '0,           1, 1, 32'h5A5A5A5A, 2, 0);
        add_row(akvm_pkg::FN_LOOKUP, '0,           '0,           1, 0, '0,           2, 0);
        add_row(akvm_pkg::FN_ERASE,  32'h12345678, '0,           1, 1, '0,           1, 0);
        add_row(akvm_pkg::FN_CLEAR,  32'h12345678, VAL_ALL1,     1, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_LOOKUP, KEY_ALL1,     '0,           1, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_CLEAR,  '0,           '0,           1, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_STORE,  32'h80000000, 32'h00000001, 0, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_FETCH,  32'h00000001, 32'h80000000, 0, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_STORE,  32'h7FFFFFFF, 32'hFFFFFFFE, 0, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_ERASE,  32'h00000001, '0,           0, 0, '0,           0, 0);
        add_row(akvm_pkg::FN_LOOKUP, 32'h7FFFFFFF, '0,           0, 0, '0,           0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        // Random blocks. The first one always fills the table past capacity so that
        // refused inserts are seen early; after that fills, drains and mixes follow in random order.
        sent = 0;
        kind = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (kind < 2)
            begin
                // fill: fresh keys until a few inserts past full are refused
                n = akvm_pkg::CAPACITY - table_fill + $urandom_range(1, 4);
                repeat (n)
                    send_random($urandom_range(0, 1) ? akvm_pkg::FN_STORE : akvm_pkg::FN_FETCH,
                                $urandom);
                repeat (4)
                    send_random(akvm_pkg::FN_LOOKUP, pick_key());
                sent += n + 4;
            end
            else if (kind == 2)
            begin
                // drain: table_fill + 2 erases of picked keys, mostly keys at random positions in the table
                n = table_fill + 2;
                repeat (n)
                    send_random(akvm_pkg::FN_ERASE, pick_key());
                sent += n;
            end
            else
            begin
                repeat (40)
                    send_random(pick_func(), pick_key());
                sent += 40;
            end
            kind = $urandom_range(0, 9);
        end
        in_valid <= 1'b0;

        // Let the last result words come out, then a short quiet tail.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_array_key_value_map passed");
        else
            $display("tb_array_key_value_map failed");
        $finish;
    end

    // Receiver: random stalls per word, one long back-off so the block fills up
    // and holds off its input while the sender keeps offering.
    initial
    begin
        int          stall;
        map_result_t exp_res;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (results_taken == HOLD_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                stall = take_burst ? 0 : $urandom_range(0, 19);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_taken++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("found",       32'(exp_res.found),       32'(found));
                check_field("read_value",  exp_res.read_value,       read_value);
                check_field("entry_count", 32'(exp_res.entry_count), 32'(entry_count));
                check_field("full_error",  32'(exp_res.full_error),  32'(full_error));
            end
        end
    end

    // Watchdog: a stretch with no word moving on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_array_key_value_map failed");
                $finish;
            end
        end
    end

endmodule
